FILE: hw/rtl/positional_list_insert_delete_core_macros.svh
// assertion macros for the positional list core
`ifndef POSITIONAL_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_CORE_MACROS_SVH

// same-cycle implication, checked outside reset
`define PLID_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PLID_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/plid_pkg.sv
// shared constants, codes and control types of the positional list core
package plid_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = ((CNT_W > 7) ? CNT_W : 7) + 1;

  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_DELETE = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_INVALID = 2'd1;
  localparam logic [1:0] STAT_FULL    = 2'd2;

  typedef enum logic [1:0] {
    OP_REJ,
    OP_INS,
    OP_DEL,
    OP_RD
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_WR,
    S_FIN
  } ctl_state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic wr;
    logic fin;
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic more;
  } sts_t;

endpackage

FILE: hw/rtl/plid_datapath.sv
// list memory, shift cursor, count register and result registers
module plid_datapath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  plid_pkg::cmd_t       cmd,
  input  logic [1:0]           in_req_type,
  input  logic [6:0]           in_position,
  input  logic signed [31:0]   in_value,
  output plid_pkg::sts_t       sts,
  output logic [1:0]           out_status,
  output logic [6:0]           out_entry_count,
  output logic signed [31:0]   out_read_value
);
  import plid_pkg::*;

  logic [31:0]       mem [DEPTH];
  logic [31:0]       rdata_r;
  op_t               op_r;
  logic [1:0]        stat_r;
  logic [ADDR_W-1:0] k_r;
  logic [ADDR_W-1:0] cursor_r;
  logic [31:0]       val_r;
  logic [CNT_W-1:0]  count_r;
  logic [1:0]        out_stat_r;
  logic [6:0]        out_cnt_r;
  logic [31:0]       out_val_r;

  op_t               op_in;
  logic [1:0]        stat_in;
  logic [CMP_W-1:0]  pos_e;
  logic [CMP_W-1:0]  cnt_e;
  logic [CMP_W-1:0]  kk;
  logic [ADDR_W-1:0] raddr;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic [CNT_W-1:0]  count_nxt;
  logic [CMP_W-1:0]  count_out_e;

  // request decode against the current count
  always_comb begin
    pos_e   = CMP_W'(in_position);
    cnt_e   = CMP_W'(count_r);
    kk      = pos_e - CMP_W'(1);
    op_in   = OP_REJ;
    stat_in = STAT_INVALID;
    case (in_req_type)
      REQ_INSERT: begin
        if (pos_e == '0 || pos_e > cnt_e + CMP_W'(1)) begin
          stat_in = STAT_INVALID;
        end else if (count_r == CNT_W'(DEPTH)) begin
          stat_in = STAT_FULL;
        end else begin
          op_in   = OP_INS;
          stat_in = STAT_DONE;
        end
      end
      REQ_DELETE: begin
        if (pos_e != '0 && pos_e <= cnt_e) begin
          op_in   = OP_DEL;
          stat_in = STAT_DONE;
        end
      end
      REQ_READ: begin
        if (pos_e != '0 && pos_e <= cnt_e) begin
          op_in   = OP_RD;
          stat_in = STAT_DONE;
        end
      end
      default: begin
        op_in   = OP_REJ;
        stat_in = STAT_INVALID;
      end
    endcase
  end

  always_comb begin
    sts.op   = op_r;
    sts.more = 1'b0;
    raddr    = cursor_r;
    case (op_r)
      OP_INS: begin
        sts.more = (cursor_r > k_r);
        raddr    = cursor_r - ADDR_W'(1);
      end
      OP_DEL: begin
        sts.more = (CNT_W'(cursor_r) + CNT_W'(1)) < count_r;
        raddr    = cursor_r + ADDR_W'(1);
      end
      default: begin
        sts.more = 1'b0;
        raddr    = cursor_r;
      end
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = cursor_r;
    wdata = rdata_r;
    if (cmd.wr) begin
      we = 1'b1;
    end else if (cmd.fin && op_r == OP_INS) begin
      we    = 1'b1;
      waddr = k_r;
      wdata = val_r;
    end
  end

  always_comb begin
    count_nxt = count_r;
    case (op_r)
      OP_INS:  count_nxt = count_r + CNT_W'(1);
      OP_DEL:  count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
    count_out_e = CMP_W'(count_nxt);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      op_r    <= OP_REJ;
    end else begin
      if (cmd.load) begin
        op_r <= op_in;
      end
      if (cmd.fin) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      stat_r   <= stat_in;
      k_r      <= kk[ADDR_W-1:0];
      val_r    <= in_value;
      cursor_r <= (op_in == OP_INS) ? count_r[ADDR_W-1:0] : kk[ADDR_W-1:0];
    end else if (cmd.wr) begin
      cursor_r <= (op_r == OP_INS) ? cursor_r - ADDR_W'(1) : cursor_r + ADDR_W'(1);
    end
    if (cmd.fin) begin
      out_stat_r <= stat_r;
      out_cnt_r  <= count_out_e[6:0];
      out_val_r  <= (op_r == OP_RD) ? rdata_r : '0;
    end
  end

  assign out_status      = out_stat_r;
  assign out_entry_count = out_cnt_r;
  assign out_read_value  = out_val_r;

endmodule

FILE: hw/rtl/plid_ctrl.sv
// sequencer for accept, shift steps and result hand-off
module plid_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  output logic           out_tvalid,
  input  logic           out_tready,
  input  plid_pkg::sts_t sts,
  output plid_pkg::cmd_t cmd
);
  import plid_pkg::*;

  ctl_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_tready;
    cmd           = '0;
    in_tready     = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        case (sts.op)
          OP_RD: begin
            cmd.rd    = 1'b1;
            state_nxt = S_FIN;
          end
          OP_INS, OP_DEL: begin
            if (sts.more) begin
              cmd.rd    = 1'b1;
              state_nxt = S_WR;
            end else begin
              state_nxt = S_FIN;
            end
          end
          default: state_nxt = S_FIN;
        endcase
      end
      S_WR: begin
        cmd.wr    = 1'b1;
        state_nxt = S_RD;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_tvalid = out_valid_r;

endmodule

FILE: hw/rtl/positional_list_insert_delete_core.sv
// top level of the positional list core: ordered list with insert, delete and read
//
// in channel: one request per transfer (req_type, position, value); out channel:
// one result per request (status, entry_count, read_value), in request order.
// a request is taken only while the core is idle; the result sits in an output
// register, so the next request may be taken while that result waits.
// after a request transfer the core decodes it: a read does one memory read,
// a rejected request none, and an insert or delete moves each entry from the
// position on (insert) or after it (delete) by one place, each shifted entry
// costing one memory read and one memory write on the list memory. the result
// is then registered, and result valid rises on the edge that returns the core
// to idle.
// reset (synchronous, active low) empties the list; memory contents are
// left as they are and only written cells are ever read.
// if the receiver stalls, the result holds; a following request runs up to
// its final step and waits there until the output register is free.
module positional_list_insert_delete_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // req_type[1:0], position[8:2], value[40:9]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata   // status[1:0], entry_count[8:2], read_value[40:9]
);
  import plid_pkg::*;

  `include "positional_list_insert_delete_core_macros.svh"

  cmd_t               cmd;
  sts_t               sts;
  logic [1:0]         res_status;
  logic [6:0]         res_count;
  logic signed [31:0] res_value;

  plid_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  plid_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_req_type     (in_tdata[1:0]),
    .in_position     (in_tdata[8:2]),
    .in_value        (in_tdata[40:9]),
    .sts             (sts),
    .out_status      (res_status),
    .out_entry_count (res_count),
    .out_read_value  (res_value)
  );

  assign out_tdata = {7'b0, res_value, res_count, res_status};

  `PLID_ASSERT_IMP(a_fin_slot_free, cmd.fin, !out_tvalid || out_tready, "result overwrote a pending transfer")
  `PLID_ASSERT_IMP(a_fail_zero_value, out_tvalid && res_status != STAT_DONE, res_value == '0, "failed request returned a value")
  `PLID_ASSERT_NXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready, "request taken while busy")
  `PLID_ASSERT_IMP(a_wr_after_rd, cmd.wr, $past(cmd.rd), "shift write without preceding read")

endmodule
